@@ sv/apsp_pkg.sv @@
// shared types and constants for the all-pairs shortest path block
package apsp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VERTEX_BITS  = 4;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 24;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]             mode;
        logic [VERTEX_BITS-1:0] src_vertex;
        logic [VERTEX_BITS-1:0] dst_vertex;
        logic [WEIGHT_BITS-1:0] edge_weight;
    } apsp_in_t;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        logic                 reachable;
        logic                 done_res;
    } apsp_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    localparam int unsigned VCOUNT_BITS = 5;
    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 5'd16;

endpackage

@@ sv/all_pairs_shortest_path.sv @@
// top level: rotating chain of distance cells with a sequencer
// The matrix lives in a chain of MAX_VERTICES squared cells that rotates one entry per
// cycle past cell 0 while a pass is in progress. Clear, load and read take one pass. A run
// takes one pass to pick up pivot row and column 0, then one pass per active vertex, in
// which each active entry is relaxed as it passes into the tail. One request is in work
// at a time; the result sits in an output register until taken, and the next request is
// taken no sooner than the cycle after that. After reset the matrix is cleared by one
// pass through all cells before the first request is taken.
module all_pairs_shortest_path
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  apsp_pkg::apsp_in_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output apsp_pkg::apsp_out_t               out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [apsp_pkg::VCOUNT_BITS-1:0]  cfg_data
);
    import apsp_pkg::*;

    localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
    localparam int VB    = VERTEX_BITS;
    localparam int PB    = 2 * VERTEX_BITS;
    localparam logic [DIST_BITS-1:0] INF = '1;

    logic [DIST_BITS-1:0] cell_q [CELLS];
    logic [DIST_BITS-1:0] feed;
    logic                 shift;
    logic                 relax;

    state_t           state_reg, state_next;
    apsp_in_t         req_reg, req_next;
    logic [PB-1:0]    pos_reg, pos_next;
    logic [VB-1:0]    k_reg, k_next;
    logic [VCOUNT_BITS-1:0] vcnt_reg;
    apsp_out_t        res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    // two banks of pivot row and column, selected by pivot parity
    logic [DIST_BITS-1:0] row_k_reg [2][MAX_VERTICES];
    logic [DIST_BITS-1:0] col_k_reg [2][MAX_VERTICES];
    logic             wb_valid_reg;
    logic [PB-1:0]    wb_pos_reg;
    logic [VB-1:0]    wb_k_reg;

    // current entry coordinates; cell 0 holds entry pos
    logic [VB-1:0] ci, cj;
    logic [VB-1:0] wb_i, wb_j;
    logic [VB-1:0] cap_k;
    logic [VB:0]   n_act;
    logic          act;
    logic [DIST_BITS-1:0] wval;

    always_comb
    begin
        ci   = pos_reg[PB-1:VB];
        cj   = pos_reg[VB-1:0];
        wb_i = wb_pos_reg[PB-1:VB];
        wb_j = wb_pos_reg[VB-1:0];
        if (vcnt_reg == '0)
            n_act = (VB+1)'(1);
        else if (32'(vcnt_reg) > MAX_VERTICES)
            n_act = (VB+1)'(MAX_VERTICES);
        else
            n_act = (VB+1)'(vcnt_reg);
        act = ({1'b0, ci} < n_act) && ({1'b0, cj} < n_act);
        // weights are narrower than distances, so a load never reaches unreachable
        wval = DIST_BITS'(req_reg.edge_weight);
        // pivot picked up in this pass: 0 before a run, the next one during a run
        cap_k = (state_reg == ST_RUN) ? k_reg + 1'b1 : '0;
    end

    // cell chain: entry leaves cell 0 and re-enters at the tail
    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            logic [DIST_BITS-1:0] din;
            if (g == CELLS - 1)
            begin : g_tail
                assign din = feed;
            end
            else
            begin : g_mid
                assign din = cell_q[g+1];
            end
            if (g == CELLS - 1)
            begin : g_relax
                apsp_cell #(.DIST_BITS(DIST_BITS)) u_cell (
                    .clk(clk), .shift(shift), .relax(relax), .din(din),
                    .via_a(col_k_reg[k_reg[0]][ci]), .via_b(row_k_reg[k_reg[0]][cj]),
                    .dout(cell_q[g]));
            end
            else
            begin : g_plain
                apsp_cell #(.DIST_BITS(DIST_BITS)) u_cell (
                    .clk(clk), .shift(shift), .relax(1'b0), .din(din),
                    .via_a(INF), .via_b(INF), .dout(cell_q[g]));
            end
        end
    endgenerate

    // feed value and relax enable for the tail of the chain
    always_comb
    begin
        feed  = cell_q[0];
        relax = 1'b0;
        unique case (state_reg)
            ST_INIT, ST_CLEAR: feed = (ci == cj) ? '0 : INF;
            ST_RUN:   relax = act;
            ST_IDLE, ST_DRAIN, ST_OUT: feed = cell_q[0];
            default:  feed = cell_q[0];
        endcase
        if (state_reg == ST_DRAIN && mode_t'(req_reg.mode) == MODE_LOAD && act
            && ci == req_reg.src_vertex && cj == req_reg.dst_vertex)
            feed = wval;
    end

    // pivot row and column capture from the entry written to the tail last cycle
    always_ff @(posedge clk)
    begin
        if (wb_valid_reg && wb_i == wb_k_reg)
            row_k_reg[wb_k_reg[0]][wb_j] <= cell_q[CELLS-1];
        if (wb_valid_reg && wb_j == wb_k_reg)
            col_k_reg[wb_k_reg[0]][wb_i] <= cell_q[CELLS-1];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        shift          = 1'b0;
        if (res_valid_reg && !out_stall)
            res_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (in_valid && !res_valid_reg)
                begin
                    req_next = in_data;
                    unique case (mode_t'(in_data.mode))
                        MODE_CLEAR: state_next = ST_CLEAR;
                        MODE_RUN:   state_next = ST_DRAIN;
                        MODE_LOAD, MODE_READ: state_next = ST_DRAIN;
                        default:    state_next = ST_DRAIN;
                    endcase
                    res_next.distance  = '0;
                    res_next.reachable = 1'b0;
                    res_next.done_res  = 1'b1;
                end
            end
            ST_INIT, ST_CLEAR, ST_DRAIN, ST_RUN:
            begin
                shift    = 1'b1;
                pos_next = pos_reg + 1'b1;
                if (state_reg == ST_DRAIN && mode_t'(req_reg.mode) == MODE_READ
                    && ci == req_reg.src_vertex && cj == req_reg.dst_vertex)
                begin
                    if (act)
                        res_next.distance = cell_q[0];
                    else
                        res_next.distance = INF;
                    res_next.reachable = res_next.distance != INF;
                end
                if (pos_reg == PB'(CELLS - 1))
                begin
                    pos_next = '0;
                    if (state_reg == ST_INIT)
                        state_next = ST_IDLE;
                    else if (mode_t'(req_reg.mode) == MODE_RUN && state_reg == ST_DRAIN)
                        state_next = ST_RUN;
                    else if (state_reg == ST_RUN && {1'b0, k_reg} + 1'b1 < n_act)
                        k_next = k_reg + 1'b1;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                res_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            pos_reg       <= '0;
            k_reg         <= '0;
            res_valid_reg <= 1'b0;
            vcnt_reg      <= VCOUNT_RESET;
            req_reg       <= '0;
            wb_valid_reg  <= 1'b0;
            wb_pos_reg    <= '0;
            wb_k_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            k_reg         <= k_next;
            res_valid_reg <= res_valid_next;
            req_reg       <= req_next;
            wb_valid_reg  <= shift;
            wb_pos_reg    <= pos_reg;
            wb_k_reg      <= cap_k;
            if (cfg_valid && cfg_ready)
                vcnt_reg <= cfg_data;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign in_stall  = (state_reg != ST_IDLE) || res_valid_reg;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ sv/apsp_cell.sv @@
// one matrix entry cell: holds a distance, shifts along the chain, relaxes the entry as it shifts in
module apsp_cell
#(
    parameter int DIST_BITS = 24
)
(
    input  logic                 clk,
    input  logic                 shift,
    input  logic                 relax,
    input  logic [DIST_BITS-1:0] din,
    input  logic [DIST_BITS-1:0] via_a,
    input  logic [DIST_BITS-1:0] via_b,
    output logic [DIST_BITS-1:0] dout
);
    localparam logic [DIST_BITS-1:0] INF = '1;

    logic [DIST_BITS-1:0] d_reg;
    logic [DIST_BITS-1:0] d_next;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] cand;
    logic                 take;

    // saturating candidate through the pivot
    always_comb
    begin
        sum  = {1'b0, via_a} + {1'b0, via_b};
        cand = (sum >= {1'b0, INF}) ? INF : sum[DIST_BITS-1:0];
        take = relax && (via_a != INF) && (via_b != INF) && (cand < din);
        d_next = take ? cand : din;
    end

    // entry register, updated on each chain shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            d_reg <= d_next;
        end
    end

    assign dout = d_reg;

endmodule

@@ sv/apsp_checker.sv @@
// port-level checks for the all-pairs shortest path block
module apsp_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input apsp_pkg::apsp_out_t out_data
);
    import apsp_pkg::*;

    // every result marks completion
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.done_res)
        else $error("result without done");

    // reachable agrees with the distance code, or a zero distance is flagged unreachable
    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.reachable == (out_data.distance != '1)) ||
                      (out_data.distance == '0 && !out_data.reachable))
        else $error("reachable flag mismatch");

    // no request is taken while a result is pending
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken with result pending");

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

@@ tb/all_pairs_shortest_path_test.sv @@
// self-checking testbench for the all-pairs shortest path block
`timescale 1ns / 100ps

// scoreboard: predicts each request's result and checks the block against it
class apsp_scoreboard;
    logic [23:0] dist_q [0:15][0:15];
    logic [4:0]  vcount;
    apsp_pkg::apsp_out_t pending_q [$];
    int errors;
    int checked;
    int reads_reachable;

    function new();
        errors          = 0;
        checked         = 0;
        reads_reachable = 0;
        vcount          = apsp_pkg::VCOUNT_RESET;
        clear_matrix();
    endfunction

    function void clear_matrix();
        for (int r = 0; r < 16; r++)
            for (int c = 0; c < 16; c++)
                dist_q[r][c] = (r == c) ? 24'd0 : 24'hFFFFFF;
    endfunction

    function int active_n();
        if (vcount == 0)
            return 1;
        if (vcount > 16)
            return 16;
        return int'(vcount);
    endfunction

    // floyd-warshall over the active vertices, sums saturate to unreachable
    function void relax();
        int n;
        logic [24:0] s;
        n = active_n();
        for (int k = 0; k < n; k++)
            for (int i = 0; i < n; i++)
            begin
                if (dist_q[i][k] == 24'hFFFFFF)
                    continue;
                for (int j = 0; j < n; j++)
                begin
                    if (dist_q[k][j] == 24'hFFFFFF)
                        continue;
                    s = dist_q[i][k] + dist_q[k][j];
                    if (s > 25'hFFFFFF)
                        s = 25'hFFFFFF;
                    if (s[23:0] < dist_q[i][j])
                        dist_q[i][j] = s[23:0];
                end
            end
    endfunction

    // accepted request: update the matrix and queue the expected result
    function void note_request(apsp_pkg::apsp_in_t req);
        apsp_pkg::apsp_out_t res;
        int n;
        n             = active_n();
        res.distance  = 24'd0;
        res.reachable = 1'b0;
        res.done_res  = 1'b1;
        case (apsp_pkg::mode_t'(req.mode))
            apsp_pkg::MODE_CLEAR: clear_matrix();
            apsp_pkg::MODE_LOAD:
                if (req.src_vertex < n && req.dst_vertex < n)
                    dist_q[req.src_vertex][req.dst_vertex] = {8'd0, req.edge_weight};
            apsp_pkg::MODE_RUN: relax();
            default:
            begin
                if (req.src_vertex < n && req.dst_vertex < n)
                    res.distance = dist_q[req.src_vertex][req.dst_vertex];
                else
                    res.distance = 24'hFFFFFF;
                res.reachable = (res.distance != 24'hFFFFFF);
                if (res.reachable)
                    reads_reachable++;
            end
        endcase
        pending_q.push_back(res);
    endfunction

    function void check_result(apsp_pkg::apsp_out_t act);
        apsp_pkg::apsp_out_t exp_res;
        checked++;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, act);
            errors++;
            return;
        end
        exp_res = pending_q.pop_front();
        if (act.distance !== exp_res.distance)
        begin
            $display("%0t: distance expected %h actual %h", $time, exp_res.distance,
                     act.distance);
            errors++;
        end
        if (act.reachable !== exp_res.reachable)
        begin
            $display("%0t: reachable expected %b actual %b", $time, exp_res.reachable,
                     act.reachable);
            errors++;
        end
        if (act.done_res !== exp_res.done_res)
        begin
            $display("%0t: done_res expected %b actual %b", $time, exp_res.done_res,
                     act.done_res);
            errors++;
        end
    endfunction
endclass

module all_pairs_shortest_path_test;
    import apsp_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    apsp_in_t  in_data;
    logic      out_valid;
    logic      out_stall;
    apsp_out_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [4:0] cfg_data;

    apsp_scoreboard sb;
    int  cycle_count;
    int  sent_count;
    int  stall_mode;

    all_pairs_shortest_path i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("all_pairs_shortest_path: mismatch");
            $finish;
        end
    end

    // result side: stall pattern, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(out_data);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // one request; waits for acceptance, then an optional idle gap
    task automatic send_request(input apsp_in_t req, input int gap);
        in_data  <= req;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(req);
        sent_count++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(input mode_t m, input int s, input int d, input int w,
                               input int gap);
        apsp_in_t req;
        req.mode        = m;
        req.src_vertex  = 4'(s);
        req.dst_vertex  = 4'(d);
        req.edge_weight = 16'(w);
        send_request(req, gap);
    endtask

    // wait for all results, then a pause before the register write
    task automatic drain_and_config(input logic [4:0] count);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.vcount = count;
    endtask

    // random graph phase: mostly load, run, read sequences
    task automatic random_phase(input int items);
        int n;
        int burst;
        int sel;
        n     = sb.active_n();
        burst = $urandom_range(1, 8);
        for (int t = 0; t < items; t++)
        begin
            apsp_in_t req;
            sel = $urandom_range(0, 99);
            req.src_vertex  = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, n - 1));
            req.dst_vertex  = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, n - 1));
            req.edge_weight = 16'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                              : $urandom_range(0, 200));
            if (sel < 3)
                req.mode = MODE_CLEAR;
            else if (sel < 50)
                req.mode = MODE_LOAD;
            else if (sel < 58)
                req.mode = MODE_RUN;
            else
                req.mode = MODE_READ;
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                send_request(req, $urandom_range(1, 6));
            end
            else
                send_request(req, 0);
        end
    endtask

    initial
    begin
        sb          = new();
        cycle_count = 0;
        sent_count  = 0;
        stall_mode  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 5'd16;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset matrix, extremes, self edge, largest weights, clear
        send_fields(MODE_READ, 0, 0, 0, 0);
        send_fields(MODE_READ, 15, 0, 0, 0);
        send_fields(MODE_LOAD, 0, 15, 16'hFFFF, 0);
        send_fields(MODE_LOAD, 15, 14, 16'hFFFF, 0);
        send_fields(MODE_LOAD, 14, 1, 16'hFFFF, 0);
        send_fields(MODE_LOAD, 3, 3, 16'h5A5A, 1);
        send_fields(MODE_LOAD, 1, 2, 0, 0);
        send_fields(MODE_RUN, 0, 0, 0, 0);
        send_fields(MODE_READ, 0, 1, 0, 0);
        send_fields(MODE_READ, 0, 2, 0, 2);
        send_fields(MODE_READ, 3, 3, 0, 0);
        send_fields(MODE_READ, 15, 15, 0, 0);
        send_fields(MODE_CLEAR, 15, 15, 16'hFFFF, 0);
        send_fields(MODE_READ, 0, 15, 0, 0);
        send_fields(MODE_READ, 3, 3, 0, 0);

        // small graph with out of range load and read
        drain_and_config(5'd4);
        stall_mode = 1;
        send_fields(MODE_LOAD, 0, 1, 7, 0);
        send_fields(MODE_LOAD, 1, 2, 9, 0);
        send_fields(MODE_LOAD, 2, 5, 3, 0);
        send_fields(MODE_LOAD, 9, 0, 1, 0);
        send_fields(MODE_RUN, 0, 0, 0, 0);
        send_fields(MODE_READ, 0, 2, 0, 0);
        send_fields(MODE_READ, 2, 5, 0, 0);
        send_fields(MODE_READ, 2, 0, 0, 0);
        random_phase(25);

        // register extremes, including out of range counts
        drain_and_config(5'd1);
        stall_mode = 2;
        random_phase(12);
        drain_and_config(5'd0);
        random_phase(8);
        drain_and_config(5'd31);
        stall_mode = 0;
        random_phase(20);
        drain_and_config(5'd16);
        stall_mode = 1;
        random_phase(25);
        drain_and_config(5'd7);
        stall_mode = 2;
        random_phase(25);

        // wait for the last results, then a settling pause
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);
        $display("sent %0d requests, checked %0d results, %0d reachable reads",
                 sent_count, sb.checked, sb.reads_reachable);
        $display("vertex counts 16, 4, 1, 0, 31, 16, 7 with varied stall patterns");
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("all_pairs_shortest_path: match");
        else
            $display("all_pairs_shortest_path: mismatch");
        $finish;
    end
endmodule

@@ all_pairs_shortest_path.f @@
sv/apsp_pkg.sv
sv/apsp_cell.sv
sv/all_pairs_shortest_path.sv
sv/apsp_checker.sv
tb/all_pairs_shortest_path_test.sv
